[rtl/rdc_pkg.sv]
// Shared constants, types and the digit-to-ASCII function of the radix digit converter.
package rdc_pkg;

  localparam int VALUE_WIDTH = 31;
  localparam int STACK_DEPTH = 32;

  localparam int RADIX_W  = 5;
  localparam int DIGIT_W  = 4;
  localparam int CHAR_W   = 7;

  localparam int IN_TDATA_W  = ((VALUE_WIDTH + RADIX_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((CHAR_W + 7) / 8) * 8;

  localparam int DIV_STEPS = (VALUE_WIDTH + DIGIT_W - 1) / DIGIT_W;
  localparam int SHIFT_W   = DIV_STEPS * DIGIT_W;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);
  localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W    = $clog2(STACK_DEPTH);

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

  localparam logic [DIGIT_W-1:0] DIGIT_ALPHA_START = DIGIT_W'(10);
  localparam logic [CHAR_W-1:0]  ASCII_ZERO        = CHAR_W'(48);
  localparam logic [CHAR_W-1:0]  ASCII_ALPHA       = CHAR_W'(65);

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [RADIX_W-1:0] radix_t;
  typedef logic [CHAR_W-1:0]  char_t;

  function automatic char_t ascii_of(input digit_t d);
    char_t c;
    if (d < DIGIT_ALPHA_START) begin
      c = ASCII_ZERO + CHAR_W'(d);
    end else begin
      c = ASCII_ALPHA + CHAR_W'(d - DIGIT_ALPHA_START);
    end
    return c;
  endfunction

endpackage

[rtl/radix_digit_converter_core.sv]
// Top level of the radix digit converter: nibble-serial divider, digit stack and output stage.
// Each digit comes from a pass of the divider over the whole quotient, one nibble of the quotient a cycle.
// All digits of a value are divided out first; each character then passes a stack read and an emit state.
// The converter works on one item at a time.
// The next item is accepted as soon as the final character sits in the output register.
// Reset is synchronous and active low; the digit stack is not cleared.
module radix_digit_converter_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [rdc_pkg::IN_TDATA_W-1:0]   in_tdata,   // value, radix
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [rdc_pkg::OUT_TDATA_W-1:0]  out_tdata,  // char_code
  output logic                             out_tlast
);
  import rdc_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_RD, S_EMIT} state_t;

  state_t                state_r;
  logic [SHIFT_W-1:0]    quot_r;
  logic [SHIFT_W-1:0]    quot_nxt;
  digit_t                rem_r;
  digit_t                rem_nxt;
  logic [DIGIT_W-1:0]    q_nib;
  radix_t                radix_r;
  radix_t                radix_in;
  logic [STEP_W-1:0]     step_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [CNT_W-1:0]      cnt_m1;
  logic [ADDR_W-1:0]     rd_addr;
  logic                  push_en;
  logic                  last_step;
  digit_t                stack_mem [STACK_DEPTH];
  digit_t                rd_data_r;
  logic                  out_valid_r;
  char_t                 out_char_r;
  logic                  out_last_r;

  always_comb begin
    radix_in = in_tdata[VALUE_WIDTH +: RADIX_W];
    if (radix_in < RADIX_MIN) begin
      radix_in = RADIX_MIN;
    end else if (radix_in > RADIX_MAX) begin
      radix_in = RADIX_MAX;
    end
  end

  rdc_div_slice u_slice (
    .rem_in    (rem_r),
    .nibble_in (quot_r[SHIFT_W-1 -: DIGIT_W]),
    .radix     (radix_r),
    .rem_out   (rem_nxt),
    .quot_out  (q_nib)
  );

  assign quot_nxt  = (quot_r << DIGIT_W) | SHIFT_W'(q_nib);
  assign last_step = (step_r == STEP_W'(DIV_STEPS - 1));
  assign push_en   = (state_r == S_DIV) && last_step && (cnt_r < CNT_W'(STACK_DEPTH));
  assign cnt_m1    = cnt_r - CNT_W'(1);
  assign rd_addr   = cnt_m1[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (push_en) begin
      stack_mem[cnt_r[ADDR_W-1:0]] <= rem_nxt;
    end
    if (state_r == S_RD) begin
      rd_data_r <= stack_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      step_r      <= '0;
    end else begin
      if (out_valid_r && out_tready && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            quot_r  <= SHIFT_W'(in_tdata[VALUE_WIDTH-1:0]);
            radix_r <= radix_in;
            rem_r   <= '0;
            step_r  <= '0;
            cnt_r   <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          quot_r <= quot_nxt;
          if (last_step) begin
            if (cnt_r < CNT_W'(STACK_DEPTH)) begin
              cnt_r <= cnt_r + CNT_W'(1);
            end
            rem_r  <= '0;
            step_r <= '0;
            if (quot_nxt == '0) begin
              state_r <= S_RD;
            end
          end else begin
            rem_r  <= rem_nxt;
            step_r <= step_r + STEP_W'(1);
          end
        end
        S_RD: begin
          cnt_r   <= cnt_m1;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_char_r  <= ascii_of(rd_data_r);
            out_last_r  <= (cnt_r == '0);
            state_r     <= (cnt_r == '0) ? S_IDLE : S_RD;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - CHAR_W){1'b0}}, out_char_r};
  assign out_tlast  = out_last_r;

endmodule

[rtl/rdc_div_slice.sv]
// Four restoring division steps: divides a remainder and one dividend nibble by the radix.
module rdc_div_slice (
  input  rdc_pkg::digit_t                 rem_in,
  input  logic [rdc_pkg::DIGIT_W-1:0]     nibble_in,
  input  rdc_pkg::radix_t                 radix,
  output rdc_pkg::digit_t                 rem_out,
  output logic [rdc_pkg::DIGIT_W-1:0]     quot_out
);
  import rdc_pkg::*;

  always_comb begin
    digit_t             r;
    logic [DIGIT_W:0]   t;
    r        = rem_in;
    quot_out = '0;
    for (int i = DIGIT_W - 1; i >= 0; i--) begin
      t = {r, nibble_in[i]};
      if (t >= radix) begin
        t           = t - radix;
        quot_out[i] = 1'b1;
      end
      r = t[DIGIT_W-1:0];
    end
    rem_out = r;
  end

endmodule

[rtl/rdc_checker.sv]
// Port-level checks of the radix digit converter, bound to its top level.
module rdc_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [rdc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                             out_tlast
);
  import rdc_pkg::*;

  logic [CHAR_W-1:0] ch;
  assign ch = out_tdata[CHAR_W-1:0];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("Stalled output item changed.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("Input accepted again while a conversion is running.");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (ch >= 7'd48 && ch <= 7'd57) || (ch >= 7'd65 && ch <= 7'd70))
    else $error("Output character is not a hexadecimal digit.");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_W-1:CHAR_W] == '0)
    else $error("Output padding bits are not zero.");

endmodule

bind radix_digit_converter_core rdc_checker u_rdc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

[tb/sv/radix_digit_converter_core_test.sv]
// Self-checking testbench for the radix digit converter with random idling on both streams.
`timescale 1ns / 1ps

module radix_digit_converter_core_test;
  import rdc_pkg::*;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int SETTLE_CYCLES = 400;
  localparam int RANDOM_ITEMS  = 430;
  localparam int HOLD_CYCLES   = 600;
  localparam int HOLD_AT_CHARS = 250;
  localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = '1;

  typedef struct {
    logic [VALUE_WIDTH-1:0] value;
    radix_t                 radix;
    int                     gap;
    bit                     after_drain;
  } conv_item_t;

  typedef struct {
    char_t code;
    logic  last;
  } char_exp_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   rx_ready = 1'b0;
  logic                   rx_hold = 1'b0;

  conv_item_t pending_items[$];
  char_exp_t  expected_chars[$];
  int         total_items = 0;
  int         items_sent = 0;
  int         chars_seen = 0;
  int         errors = 0;
  int         cycles = 0;
  int         longest_string = 0;
  int         clamped_radix = 0;
  int         pending_gap = 0;

  assign out_tready = rx_ready & ~rx_hold;

  radix_digit_converter_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d characters outstanding.", cycles,
               expected_chars.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int effective_radix(input radix_t r);
    if (r < RADIX_MIN) begin
      return int'(RADIX_MIN);
    end else if (r > RADIX_MAX) begin
      return int'(RADIX_MAX);
    end
    return int'(r);
  endfunction

  // Queues the characters of one value, most significant digit first.
  function automatic void spell_value(input logic [VALUE_WIDTH-1:0] value, input radix_t r);
    longint unsigned rest;
    int              base;
    digit_t          digits[$];
    digit_t          d;
    char_exp_t       ch;
    base = effective_radix(r);
    if (r < RADIX_MIN || r > RADIX_MAX) begin
      clamped_radix++;
    end
    rest = longint'(value);
    if (rest == 0) begin
      digits.push_back('0);
    end
    while (rest != 0) begin
      if (digits.size() < STACK_DEPTH) begin
        digits.push_back(digit_t'(rest % base));
      end
      rest = rest / base;
    end
    if (digits.size() > longest_string) begin
      longest_string = digits.size();
    end
    while (digits.size() > 0) begin
      d = digits.pop_back();
      if (d < DIGIT_ALPHA_START) begin
        ch.code = ASCII_ZERO + char_t'(d);
      end else begin
        ch.code = ASCII_ALPHA + char_t'(d - DIGIT_ALPHA_START);
      end
      ch.last = (digits.size() == 0);
      expected_chars.push_back(ch);
    end
  endfunction

  function automatic void add_item(input logic [VALUE_WIDTH-1:0] value, input radix_t r,
                                   input int gap, input bit after_drain);
    conv_item_t it;
    it.value = value;
    it.radix = r;
    it.gap = gap;
    it.after_drain = after_drain;
    pending_items.push_back(it);
    total_items++;
  endfunction

  function automatic radix_t random_radix();
    if ($urandom_range(0, 11) == 0) begin
      return $urandom_range(0, 1) ? radix_t'($urandom_range(0, 1)) :
                                    radix_t'($urandom_range(17, 31));
    end
    return radix_t'($urandom_range(2, 16));
  endfunction

  function automatic logic [VALUE_WIDTH-1:0] random_value(input radix_t r);
    longint unsigned power;
    int              base;
    int              width;
    int              steps;
    case ($urandom_range(0, 3))
      0: return VALUE_WIDTH'($urandom);
      1: begin
        width = $urandom_range(0, VALUE_WIDTH);
        return VALUE_WIDTH'($urandom) & VALUE_WIDTH'((64'd1 << width) - 1);
      end
      2: begin
        base = effective_radix(r);
        power = 1;
        steps = $urandom_range(1, VALUE_WIDTH);
        repeat (steps) begin
          if (power * base <= longint'(VALUE_MAX)) begin
            power = power * base;
          end
        end
        return VALUE_WIDTH'(power - $urandom_range(0, 1));
      end
      default: return VALUE_WIDTH'($urandom_range(0, 20));
    endcase
  endfunction

  always @(posedge clk) begin
    conv_item_t it;
    int         gap_left;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        spell_value(in_tdata[VALUE_WIDTH-1:0], in_tdata[VALUE_WIDTH +: RADIX_W]);
        gap_left = pending_gap;
        items_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_items.size() > 0 &&
                     !(pending_items[0].after_drain && expected_chars.size() > 0)) begin
          it = pending_items.pop_front();
          pending_gap = it.gap;
          in_tdata <= IN_TDATA_W'({it.radix, it.value});
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    char_exp_t ch;
    int        stall_left;
    if (!rst_n) begin
      rx_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        chars_seen++;
        if (expected_chars.size() == 0) begin
          $error("unexpected character: char_code %0d last %0b",
                 out_tdata[CHAR_W-1:0], out_tlast);
          errors++;
        end else begin
          ch = expected_chars.pop_front();
          if (out_tdata[CHAR_W-1:0] !== ch.code) begin
            $error("char_code mismatch: expected %0d, got %0d", ch.code,
                   out_tdata[CHAR_W-1:0]);
            errors++;
          end
          if (out_tlast !== ch.last) begin
            $error("last mismatch: expected %0b, got %0b", ch.last, out_tlast);
            errors++;
          end
        end
        if (chars_seen >= 1000 && chars_seen < 1600) begin
          stall_left = 0;
        end else begin
          stall_left = $urandom_range(0, 19);
        end
      end else if (stall_left > 0) begin
        stall_left--;
      end
      rx_ready <= (stall_left == 0);
    end
  end

  // A long hold on the result side backs the converter up into its input.
  always @(posedge clk) begin
    int hold_left;
    bit hold_done;
    if (!rst_n) begin
      rx_hold <= 1'b0;
      hold_left = 0;
      hold_done = 0;
    end else begin
      if (!hold_done && chars_seen >= HOLD_AT_CHARS) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      rx_hold <= (hold_left > 0);
    end
  end

  initial begin
    radix_t r;
    int     gap;
    add_item('0, radix_t'(10), 0, 0);
    add_item('0, radix_t'(2), 3, 0);
    add_item(VALUE_MAX, radix_t'(2), 0, 0);
    add_item(VALUE_MAX, radix_t'(16), 0, 0);
    add_item(VALUE_MAX, radix_t'(10), 5, 0);
    add_item(VALUE_MAX, radix_t'(3), 0, 0);
    add_item(VALUE_WIDTH'(1), radix_t'(2), 0, 0);
    add_item(VALUE_WIDTH'(14), radix_t'(16), 0, 0);
    add_item(VALUE_WIDTH'(15), radix_t'(16), 2, 0);
    add_item(VALUE_WIDTH'(32'h00ABCDEF), radix_t'(16), 0, 0);
    add_item(VALUE_WIDTH'(32'h12345678), radix_t'(16), 0, 0);
    add_item(VALUE_WIDTH'(9), radix_t'(10), 0, 0);
    add_item(VALUE_WIDTH'(10), radix_t'(10), 0, 1);
    add_item(VALUE_WIDTH'(12345), radix_t'(0), 0, 0);
    add_item(VALUE_WIDTH'(77), radix_t'(1), 4, 0);
    add_item(VALUE_WIDTH'(65535), radix_t'(17), 0, 0);
    add_item(VALUE_MAX, radix_t'(31), 0, 0);
    add_item(VALUE_WIDTH'(32'h40000000), radix_t'(2), 0, 0);
    add_item(VALUE_WIDTH'(124), radix_t'(5), 0, 0);
    add_item(VALUE_WIDTH'(14348906), radix_t'(3), 1, 0);
    add_item(VALUE_WIDTH'(1295), radix_t'(15), 0, 0);
    add_item(VALUE_WIDTH'(32'h55555555), radix_t'(4), 0, 0);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      r = random_radix();
      gap = (i >= 300 && i < 380) ? 0 : $urandom_range(0, 19);
      add_item(random_value(r), r, gap, (i == 0 || i == 200 || i == 350));
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    while (items_sent < total_items || expected_chars.size() > 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Converted %0d values into %0d characters, longest string %0d digits.",
             items_sent, chars_seen, longest_string);
    $display("Out-of-range radix used %0d times; both streams idled and stalled at random.",
             clamped_radix);
    if (errors == 0 && expected_chars.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
